// ===== rtl/rldr_pkg.sv =====
package rldr_pkg;

    localparam int DIV_W = 36;
    localparam int DIVISOR_W = 16;
    localparam int LOG2_10_Q16 = 217706;
    localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

    localparam logic [1:0] REG_TX_POWER = 2'd0;
    localparam logic [1:0] REG_REF_LOSS = 2'd1;
    localparam logic [1:0] REG_PL_EXP = 2'd2;
    localparam logic [1:0] REG_REF_DIST = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_DIVM_GO,
        S_DIVM_WAIT,
        S_ESUM,
        S_MUL_E,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_POW,
        S_MUL_D,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef logic [30:0] root_rom_t [16];

    // 2^(2^-(j+1)) in Q30, each entry floor(sqrt(previous << 30)), chain from 2.0
    function automatic root_rom_t build_roots();
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        root_rom_t   t;
        c = 64'd2 << 30;
        for (int j = 0; j < 16; j++)
        begin
            v = c << 30;
            r = '0;
            b = 64'h4000_0000_0000_0000;
            for (int i = 0; i < 32; i++)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
            t[j] = c[30:0];
        end
        return t;
    endfunction

    localparam root_rom_t ROOT_ROM = build_roots();

endpackage

// ===== rtl/rldr_in_if.sv =====
interface rldr_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] rssi_dbm;
    logic              start_series;
    logic signed [15:0] noise_q8;

    modport source (output valid, output rssi_dbm, output start_series, output noise_q8,
                    input ready);
    modport sink (input valid, input rssi_dbm, input start_series, input noise_q8,
                  output ready);
endinterface

// ===== rtl/rldr_out_if.sv =====
interface rldr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mean_rssi_q8;
    logic [23:0]        distance_q8;
    logic               saturated;

    modport source (output valid, output mean_rssi_q8, output distance_q8, output saturated,
                    input ready);
    modport sink (input valid, input mean_rssi_q8, input distance_q8, input saturated,
                  output ready);
endinterface

// ===== rtl/rldr_div.sv =====
module rldr_div (
    input  logic             clk,
    input  logic             rst_n,
    input  rldr_pkg::div_req_t req,
    output rldr_pkg::div_rsp_t rsp
);
    import rldr_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W:0]   rem_sh;
    logic                 take;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, quot_reg[DIV_W-1]};
    assign take = (rem_sh >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quot_reg    <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? DIVISOR_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== rtl/rssi_log_distance_ranger.sv =====
// RSSI log-distance ranger.
// in_ch (sink): one RSSI sample per transaction with start_series and a Q8.8
// noise term. start_series clears the sample window before the sample is stored.
// out_ch (source): one result per input transaction: window mean (Q8.8, rounded),
// distance d0*10^((Pt-mean-noise-PL0)/(10n)) in Q16.8 metres and a saturation flag.
// APB port: four registers at byte addresses 0, 4, 8, 12 (Pt, PL0, n, d0); pready
// is tied high. Write only while the block is idle.
// Sequence: the stored samples are summed one by one, then the shared 36-step
// divider is used twice (mean and exponent) and the shared multiplier makes 16
// passes for 2^frac. One item is processed at a time; in_ch.ready is high only
// in idle, so a new transaction is taken only after the previous one has
// left the final step.
// A finished result sits in the output register, so the next item may be accepted
// while out_ch is stalled; its result then waits in the final step until the output
// register frees.
// Reset: window, count and write slot clear, registers take their reset values,
// no result is pending.
module rssi_log_distance_ranger #(
    parameter int WINDOW_LEN = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rldr_in_if.sink     in_ch,
    rldr_out_if.source  out_ch
);
    import rldr_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W = 8 + CNT_W;

    // configuration
    logic signed [15:0] tx_power_reg;
    logic signed [15:0] ref_loss_reg;
    logic [11:0]        pl_exp_reg;
    logic [15:0]        ref_dist_reg;
    logic               cfg_wr;

    // sequencer and datapath
    state_t             state_reg, state_next;
    logic signed [7:0]  win_reg [WINDOW_LEN];
    logic signed [7:0]  win_next [WINDOW_LEN];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [15:0] noise_reg, noise_next;
    logic signed [15:0] mean_reg, mean_next;
    logic               neg_reg, neg_next;
    logic [17:0]        emag_reg, emag_next;
    logic [46:0]        prod_reg, prod_next;
    logic [33:0]        y_reg, y_next;
    logic [30:0]        p_reg, p_next;
    logic [3:0]         step_reg, step_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_mean_reg, out_mean_next;
    logic [23:0]        out_dist_reg, out_dist_next;
    logic               out_sat_reg, out_sat_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // shared multiplier
    logic [30:0]        mul_a, mul_b;
    logic [61:0]        mul_p;

    // helpers
    logic [11:0]        n_eff;
    logic [14:0]        n5;
    logic [IDX_W-1:0]   slot_eff;
    logic [SUM_W-1:0]   sum_mag;
    logic [16:0]        q17;
    logic signed [18:0] e_val;
    logic signed [17:0] kk;
    logic signed [17:0] s18;
    logic [5:0]         sh;
    logic [47:0]        rnd;
    logic [47:0]        vfull;
    logic [61:0]        p_rnd;

    rldr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_power_reg <= 16'sd5120;
            ref_loss_reg <= 16'sd10240;
            pl_exp_reg   <= 12'd512;
            ref_dist_reg <= 16'd256;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_TX_POWER: tx_power_reg <= pwdata[15:0];
                REG_REF_LOSS: ref_loss_reg <= pwdata[15:0];
                REG_PL_EXP:   pl_exp_reg   <= pwdata[11:0];
                REG_REF_DIST: ref_dist_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TX_POWER: prdata = {16'd0, tx_power_reg};
            REG_REF_LOSS: prdata = {16'd0, ref_loss_reg};
            REG_PL_EXP:   prdata = {20'd0, pl_exp_reg};
            REG_REF_DIST: prdata = {16'd0, ref_dist_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.mean_rssi_q8 = out_mean_reg;
    assign out_ch.distance_q8  = out_dist_reg;
    assign out_ch.saturated    = out_sat_reg;

    // ---------------- arithmetic helpers ----------------
    assign n_eff    = (pl_exp_reg == 12'd0) ? 12'd1 : pl_exp_reg;
    assign n5       = {n_eff, 2'b00} + {3'b000, n_eff};
    assign slot_eff = in_ch.start_series ? '0 : slot_reg;
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q17      = neg_reg ? 17'(-div_rsp.quotient[16:0]) : div_rsp.quotient[16:0];
    assign e_val    = 19'(tx_power_reg) - 19'(mean_reg) - 19'(noise_reg) - 19'(ref_loss_reg);
    assign kk       = y_reg[33:16];
    assign s18      = 18'sd30 - kk;
    assign sh       = s18[5:0];
    assign rnd      = {1'b0, prod_reg} + (48'd1 << (sh - 6'd1));
    assign vfull    = rnd >> sh;
    assign mul_p    = 62'(mul_a) * 62'(mul_b);
    assign p_rnd    = mul_p + 62'(1 << 29);

    always_comb
    begin
        case (state_reg)
            S_MUL_E:
            begin
                mul_a = 31'(emag_reg);
                mul_b = 31'(LOG2_10_Q16);
            end
            S_POW:
            begin
                mul_a = p_reg;
                mul_b = ROOT_ROM[step_reg];
            end
            S_MUL_D:
            begin
                mul_a = 31'(ref_dist_reg);
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        noise_next     = noise_reg;
        mean_next      = mean_reg;
        neg_next       = neg_reg;
        emag_next      = emag_reg;
        prod_next      = prod_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_dist_next  = out_dist_reg;
        out_sat_next   = out_sat_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.start_series)
                    begin
                        for (int i = 0; i < WINDOW_LEN; i++)
                        begin
                            win_next[i] = '0;
                        end
                        count_next = CNT_W'(1);
                    end
                    else if (count_reg < CNT_W'(WINDOW_LEN))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    win_next[slot_eff] = in_ch.rssi_dbm;
                    slot_next  = (slot_eff == IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_eff + IDX_W'(1);
                    noise_next = in_ch.noise_q8;
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_DIVM_GO;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(win_reg[idx_reg[IDX_W-1:0]]);
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_DIVM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({sum_mag, 8'd0}) + DIV_W'(count_reg >> 1);
                div_req.divisor  = DIVISOR_W'(count_reg);
                neg_next         = sum_reg[SUM_W-1];
                state_next       = S_DIVM_WAIT;
            end
            S_DIVM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = q17[15:0];
                    state_next = S_ESUM;
                end
            end
            S_ESUM:
            begin
                neg_next   = e_val[18];
                emag_next  = e_val[18] ? 18'(-e_val) : e_val[17:0];
                state_next = S_MUL_E;
            end
            S_MUL_E:
            begin
                prod_next  = mul_p[46:0];
                state_next = S_DIVY_GO;
            end
            S_DIVY_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod_reg) + DIV_W'(n5);
                div_req.divisor  = {n5, 1'b0};
                state_next       = S_DIVY_WAIT;
            end
            S_DIVY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    y_next     = neg_reg ? -div_rsp.quotient[33:0] : div_rsp.quotient[33:0];
                    p_next     = 31'(1 << 30);
                    step_next  = '0;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                // fraction bit 15-step selects the root for this step
                if (y_reg[4'd15 - step_reg])
                begin
                    p_next = p_rnd[60:30];
                end
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    state_next = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                prod_next  = mul_p[46:0];
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_sat_next   = 1'b0;
                    out_dist_next  = '0;
                    if (ref_dist_reg == 16'd0)
                    begin
                        out_dist_next = '0;
                    end
                    else if (kk >= 18'sd30)
                    begin
                        out_sat_next  = 1'b1;
                        out_dist_next = DIST_MAX;
                    end
                    else if (kk <= -18'sd18)
                    begin
                        out_dist_next = '0;
                    end
                    else if (vfull > 48'(DIST_MAX))
                    begin
                        out_sat_next  = 1'b1;
                        out_dist_next = DIST_MAX;
                    end
                    else
                    begin
                        out_dist_next = vfull[23:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        noise_reg    <= noise_next;
        mean_reg     <= mean_next;
        neg_reg      <= neg_next;
        emag_reg     <= emag_next;
        prod_reg     <= prod_next;
        y_reg        <= y_next;
        p_reg        <= p_next;
        step_reg     <= step_next;
        out_mean_reg <= out_mean_next;
        out_dist_reg <= out_dist_next;
        out_sat_reg  <= out_sat_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("ready high right after accept");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> (out_dist_reg == DIST_MAX))
        else $error("saturated result not clamped");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_LEN))
        else $error("sample count beyond window");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVM_WAIT || state_reg == S_DIVY_WAIT))
        else $error("divider done while not waiting");
`endif

endmodule
